[rtl/core/pba_pkg.sv]
// shared widths and register codes for the pairwise binary association block
// no dependencies
`timescale 1ns / 1ps

package pba_pkg;

	localparam int ROW_W   = 8;
	localparam int COL_W   = 3;
	localparam int CCNT_W  = 4;
	localparam int SCALE_W = 8;
	localparam int CFG_W   = 8;
	localparam int Q32_W   = 32;
	localparam int Q16_W   = 16;

	typedef enum logic [0:0] {
		CFG_COLUMN_COUNT = 1'b0,
		CFG_ERROR_SCALE  = 1'b1
	} cfg_reg_t;

	localparam logic [CCNT_W-1:0]  COLUMN_COUNT_RST = 4'd8;
	localparam logic [SCALE_W-1:0] ERROR_SCALE_RST  = 8'd1;

endpackage

[rtl/core/pba_if.sv]
// valid/ready channel interfaces for row beats and result beats
// depends on pba_pkg
`timescale 1ns / 1ps

interface pba_row_if
	import pba_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] row_bits;
	logic             last_row;

	modport source (output valid, output row_bits, output last_row, input ready);
	modport sink   (input valid, input row_bits, input last_row, output ready);
endinterface

interface pba_res_if
	import pba_pkg::*;
	();
	logic                    valid;
	logic                    ready;
	logic [COL_W-1:0]        col_a;
	logic [COL_W-1:0]        col_b;
	logic [Q32_W-1:0]        odds_ratio;
	logic [Q32_W-1:0]        recip_sum;
	logic signed [Q16_W-1:0] correlation;
	logic [Q16_W-1:0]        mean_a;
	logic                    ratio_undefined;
	logic                    sum_undefined;
	logic                    corr_undefined;
	logic                    last_pair;

	modport source (output valid, output col_a, output col_b, output odds_ratio,
		output recip_sum, output correlation, output mean_a, output ratio_undefined,
		output sum_undefined, output corr_undefined, output last_pair, input ready);
	modport sink (input valid, input col_a, input col_b, input odds_ratio,
		input recip_sum, input correlation, input mean_a, input ratio_undefined,
		input sum_undefined, input corr_undefined, input last_pair, output ready);
endinterface

[rtl/core/pba_front.sv]
// front end: row counters and pair job sequencer
// depends on pba_pkg, pba_if
`timescale 1ns / 1ps

module pba_front
	import pba_pkg::*;
	#(
		parameter int M = 8,
		parameter int C = 16,
		localparam int AW = $clog2(M),
		localparam int JW = 2*AW + 4*C + 1
	) (
		input  logic              clk,
		input  logic              arst_n,
		pba_row_if.sink           row,
		input  logic [CCNT_W-1:0] column_count,
		output logic              job_valid,
		input  logic              job_ready,
		output logic [JW-1:0]     job_data
	);

	localparam int NP = (M * (M - 1)) >> 1;

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_EMIT = 2'b10
	} front_state_t;

	function automatic int tri_idx(int i, int j);
		return i*M - ((i*(i+1)) >> 1) + j - i - 1;
	endfunction

	front_state_t       state_q;
	logic [C-1:0]       row_total_q;
	logic [C-1:0]       col_ones_q [M];
	logic [C-1:0]       pair_q [NP];
	logic [AW-1:0]      a_q, b_q, lim_q;
	logic [AW-1:0]      lim;
	logic [C-1:0]       n11;
	logic               take, push, last;

	assign row.ready = (state_q == ST_LOAD);
	assign take      = row.valid && row.ready;
	assign job_valid = (state_q == ST_EMIT);
	assign push      = job_valid && job_ready;
	assign last      = (a_q == lim_q) && (b_q == lim_q);

	// column count clamped to 1..M, held as last index
	always_comb begin
		if (column_count == '0)
			lim = '0;
		else if (column_count > CCNT_W'(M))
			lim = AW'(M - 1);
		else
			lim = AW'(column_count - CCNT_W'(1));
	end

	// joint count for the current pair, symmetric store
	always_comb begin
		n11 = col_ones_q[a_q];
		for (int i = 0; i < M; i++)
			for (int j = i + 1; j < M; j++)
				if ((a_q == AW'(i) && b_q == AW'(j)) || (a_q == AW'(j) && b_q == AW'(i)))
					n11 = pair_q[tri_idx(i, j)];
	end

	assign job_data = {last, a_q, b_q, row_total_q, col_ones_q[a_q], col_ones_q[b_q], n11};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			row_total_q <= '0;
			a_q         <= '0;
			b_q         <= '0;
			lim_q       <= '0;
			for (int i = 0; i < M; i++)
				col_ones_q[i] <= '0;
			for (int p = 0; p < NP; p++)
				pair_q[p] <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (take) begin
						if (row_total_q != {C{1'b1}}) begin
							row_total_q <= row_total_q + C'(1);
							for (int i = 0; i < M; i++) begin
								if (row.row_bits[i])
									col_ones_q[i] <= col_ones_q[i] + C'(1);
								for (int j = i + 1; j < M; j++)
									if (row.row_bits[i] && row.row_bits[j])
										pair_q[tri_idx(i, j)] <= pair_q[tri_idx(i, j)] + C'(1);
							end
						end
						if (row.last_row) begin
							state_q <= ST_EMIT;
							lim_q   <= lim;
							a_q     <= '0;
							b_q     <= '0;
						end
					end
				end
				ST_EMIT: begin
					if (push) begin
						if (b_q == lim_q) begin
							b_q <= '0;
							a_q <= a_q + AW'(1);
						end else begin
							b_q <= b_q + AW'(1);
						end
						if (last) begin
							state_q     <= ST_LOAD;
							row_total_q <= '0;
							for (int i = 0; i < M; i++)
								col_ones_q[i] <= '0;
							for (int p = 0; p < NP; p++)
								pair_q[p] <= '0;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

[rtl/core/pba_fifo.sv]
// two-entry job queue between front and back
// no package dependencies
`timescale 1ns / 1ps

module pba_fifo #(
		parameter int W = 8
	) (
		input  logic         clk,
		input  logic         arst_n,
		input  logic         in_valid,
		output logic         in_ready,
		input  logic [W-1:0] in_data,
		output logic         out_valid,
		input  logic         out_ready,
		output logic [W-1:0] out_data
	);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   count_q;
	logic         wr, rd;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = mem_q[rd_ptr_q];
	assign wr        = in_valid && in_ready;
	assign rd        = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wr_ptr_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr)
				wr_ptr_q <= !wr_ptr_q;
			if (rd)
				rd_ptr_q <= !rd_ptr_q;
			if (wr && !rd)
				count_q <= count_q + 2'd1;
			else if (rd && !wr)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

[rtl/core/pba_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
// needs dividend >> QW below the divisor; no package dependencies
`timescale 1ns / 1ps

module pba_div #(
		parameter int DW = 18,
		parameter int VW = 16,
		parameter int QW = 17
	) (
		input  logic          clk,
		input  logic          arst_n,
		input  logic          start,
		input  logic [DW-1:0] dividend,
		input  logic [VW-1:0] divisor,
		output logic          busy,
		output logic [QW-1:0] quotient
	);

	localparam int CW = $clog2(QW + 1);

	logic [VW-1:0] rem_q;
	logic [QW-1:0] sh_q;
	logic [VW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic [VW:0]   trial;
	logic          ge;

	assign busy     = (cnt_q != '0);
	assign quotient = sh_q;
	assign trial    = {rem_q, sh_q[QW-1]};
	assign ge       = (trial >= {1'b0, div_q});

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= VW'(dividend[DW-1:QW]);
			sh_q  <= dividend[QW-1:0];
			div_q <= divisor;
		end else if (busy) begin
			rem_q <= ge ? VW'(trial - {1'b0, div_q}) : VW'(trial);
			sh_q  <= {sh_q[QW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (start)
			cnt_q <= CW'(QW);
		else if (busy)
			cnt_q <= cnt_q - CW'(1);
	end

endmodule

[rtl/core/pba_back.sv]
// back end: per-pair statistics with iterative units
// depends on pba_pkg, pba_if, pba_div
`timescale 1ns / 1ps

module pba_back
	import pba_pkg::*;
	#(
		parameter int M = 8,
		parameter int C = 16,
		localparam int AW = $clog2(M),
		localparam int JW = 2*AW + 4*C + 1
	) (
		input  logic               clk,
		input  logic               arst_n,
		input  logic               job_valid,
		output logic               job_ready,
		input  logic [JW-1:0]      job_data,
		input  logic [SCALE_W-1:0] error_scale,
		pba_res_if.source          res
	);

	localparam int W2  = 2*C;
	localparam int W4  = 4*C;
	localparam int MCW = $clog2(W2 + 1);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DIFF = 7'b0000010,
		ST_PROD = 7'b0000100,
		ST_MAG  = 7'b0001000,
		ST_SQML = 7'b0010000,
		ST_DIVW = 7'b0100000,
		ST_SQRT = 7'b1000000
	} back_state_t;

	typedef enum logic [1:0] {
		OUT_EMPTY = 2'b01,
		OUT_FULL  = 2'b10
	} out_state_t;

	back_state_t   state_q;
	out_state_t    out_q;
	logic [AW-1:0] a_q, b_q;
	logic          last_q;
	logic [C-1:0]  n_q, na_q, nb_q, n11_q;
	logic [C-1:0]  n10_q, n01_q, n00_q, nma_q, nmb_q;
	logic          zc_q, cc_q, nz_q, neg_q;
	logic [W2-1:0] den_q, num_q, c1_q, c2_q, p1_q, p2_q;
	logic [W4-1:0] mca_q, mcb_q, acca_q, accb_q;
	logic [W2-1:0] mpa_q, mpb_q;
	logic [MCW-1:0] mcnt_q;
	logic [31:0]   sv_q;
	logic [17:0]   srem_q;
	logic [15:0]   root_q;
	logic [4:0]    scnt_q;
	logic [19:0]   srem_n, st;
	logic          sq_ge;
	logic          div_start, phi_start, any_busy, out_load;

	logic          odds_busy, mean_busy, phi_busy;
	logic [3:0]    rc_busy;
	logic [31:0]   odds_quot;
	logic [16:0]   mean_quot;
	logic [30:0]   phi_quot;
	logic [16:0]   rc_quot [4];
	logic [C-1:0]  rc_div [4];

	logic [18:0]   rc_sum;
	logic [31:0]   odds_val, recip_val;
	logic [15:0]   mean_val;
	logic [15:0]   corr_val;

	assign job_ready = (state_q == ST_IDLE);
	assign div_start = (state_q == ST_MAG);
	assign phi_start = (state_q == ST_SQML) && (mcnt_q == '0);
	assign any_busy  = odds_busy || mean_busy || phi_busy || (rc_busy != 4'b0);
	assign out_load  = (state_q == ST_SQRT) && (scnt_q == '0)
		&& ((out_q == OUT_EMPTY) || res.ready);

	// odds ratio
	pba_div #(.DW(W2 + 17), .VW(W2), .QW(32)) u_div_odds (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend({1'b0, num_q, 16'b0}), .divisor(den_q),
		.busy(odds_busy), .quotient(odds_quot)
	);

	// mean of column a
	pba_div #(.DW(C + 17), .VW(C), .QW(17)) u_div_mean (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend({1'b0, na_q, 16'b0}), .divisor(n_q),
		.busy(mean_busy), .quotient(mean_quot)
	);

	// squared phi scaled by 2^30, quotient stays below 2^31
	pba_div #(.DW(W4 + 30), .VW(W4), .QW(31)) u_div_phi (
		.clk(clk), .arst_n(arst_n), .start(phi_start),
		.dividend({acca_q, 30'b0}), .divisor(accb_q),
		.busy(phi_busy), .quotient(phi_quot)
	);

	assign rc_div[0] = n11_q;
	assign rc_div[1] = n00_q;
	assign rc_div[2] = n10_q;
	assign rc_div[3] = n01_q;

	// reciprocals of the four cells
	for (genvar g = 0; g < 4; g++) begin : g_rc
		pba_div #(.DW(18), .VW(C), .QW(17)) u_div_rc (
			.clk(clk), .arst_n(arst_n), .start(div_start),
			.dividend(18'h10000), .divisor(rc_div[g]),
			.busy(rc_busy[g]), .quotient(rc_quot[g])
		);
	end

	// square root, two bits of the radicand per step
	assign srem_n = {srem_q, sv_q[31:30]};
	assign st     = {2'b0, root_q, 2'b01};
	assign sq_ge  = (srem_n >= st);

	always_comb begin
		rc_sum   = 19'(rc_quot[0]) + 19'(rc_quot[1]) + 19'(rc_quot[2]) + 19'(rc_quot[3]);
		odds_val = ((den_q == '0) || ((num_q >> 16) >= den_q)) ? 32'hFFFF_FFFF : odds_quot;
		recip_val = zc_q ? 32'hFFFF_FFFF : 32'(rc_sum) * 32'(error_scale);
		if (!nz_q)
			mean_val = '0;
		else if (mean_quot[16])
			mean_val = 16'hFFFF;
		else
			mean_val = mean_quot[15:0];
		if (cc_q)
			corr_val = '0;
		else if (neg_q)
			corr_val = 16'(~root_q + 16'd1);
		else if (root_q[15])
			corr_val = 16'h7FFF;
		else
			corr_val = root_q;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid)
					{last_q, a_q, b_q, n_q, na_q, nb_q, n11_q} <= job_data;
			end
			ST_DIFF: begin
				n10_q <= na_q - n11_q;
				n01_q <= nb_q - n11_q;
				n00_q <= n_q - na_q - nb_q + n11_q;
				nma_q <= n_q - na_q;
				nmb_q <= n_q - nb_q;
				cc_q  <= (na_q == '0) || (na_q == n_q) || (nb_q == '0) || (nb_q == n_q);
				nz_q  <= (n_q != '0);
			end
			ST_PROD: begin
				zc_q  <= (n11_q == '0) || (n10_q == '0) || (n01_q == '0) || (n00_q == '0);
				den_q <= W2'(n10_q) * W2'(n01_q);
				num_q <= W2'(n11_q) * W2'(n00_q);
				c1_q  <= W2'(n_q) * W2'(n11_q);
				c2_q  <= W2'(na_q) * W2'(nb_q);
				p1_q  <= W2'(na_q) * W2'(nma_q);
				p2_q  <= W2'(nb_q) * W2'(nmb_q);
			end
			ST_MAG: begin
				neg_q  <= (c1_q < c2_q);
				mca_q  <= W4'((c1_q < c2_q) ? c2_q - c1_q : c1_q - c2_q);
				mpa_q  <= (c1_q < c2_q) ? c2_q - c1_q : c1_q - c2_q;
				mcb_q  <= W4'(p1_q);
				mpb_q  <= p2_q;
				acca_q <= '0;
				accb_q <= '0;
			end
			ST_SQML: begin
				// shift-add products: magnitude squared and the variance product
				if (mcnt_q != '0) begin
					if (mpa_q[0])
						acca_q <= acca_q + mca_q;
					if (mpb_q[0])
						accb_q <= accb_q + mcb_q;
					mca_q <= mca_q << 1;
					mcb_q <= mcb_q << 1;
					mpa_q <= mpa_q >> 1;
					mpb_q <= mpb_q >> 1;
				end
			end
			ST_DIVW: begin
				if (!any_busy) begin
					sv_q   <= {1'b0, phi_quot};
					srem_q <= '0;
					root_q <= '0;
				end
			end
			ST_SQRT: begin
				if (scnt_q != '0) begin
					srem_q <= sq_ge ? 18'(srem_n - st) : 18'(srem_n);
					root_q <= {root_q[14:0], sq_ge};
					sv_q   <= sv_q << 2;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mcnt_q  <= '0;
			scnt_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (job_valid) state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_PROD;
				ST_PROD: state_q <= ST_MAG;
				ST_MAG: begin
					state_q <= ST_SQML;
					mcnt_q  <= MCW'(W2);
				end
				ST_SQML: begin
					if (mcnt_q == '0)
						state_q <= ST_DIVW;
					else
						mcnt_q <= mcnt_q - MCW'(1);
				end
				ST_DIVW: begin
					if (!any_busy) begin
						state_q <= ST_SQRT;
						scnt_q  <= 5'd16;
					end
				end
				ST_SQRT: begin
					if (scnt_q != '0)
						scnt_q <= scnt_q - 5'd1;
					else if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			res.col_a           <= COL_W'(a_q);
			res.col_b           <= COL_W'(b_q);
			res.odds_ratio      <= odds_val;
			res.recip_sum       <= recip_val;
			res.correlation     <= corr_val;
			res.mean_a          <= mean_val;
			res.ratio_undefined <= (den_q == '0);
			res.sum_undefined   <= zc_q;
			res.corr_undefined  <= cc_q;
			res.last_pair       <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_q <= OUT_EMPTY;
		else if (out_load)
			out_q <= OUT_FULL;
		else if (res.ready)
			out_q <= OUT_EMPTY;
	end

	assign res.valid = (out_q == OUT_FULL);

endmodule

[rtl/core/pairwise_binary_association_top.sv]
// top level of the pairwise binary association block: config registers and wiring
// depends on pba_pkg, pba_if, pba_front, pba_fifo, pba_back
`timescale 1ns / 1ps

// Rows of a binary matrix enter on the row channel, one beat per cycle, while the
// front end counts rows, ones per column and joint ones per column pair (joint
// counts are held once per unordered pair). The beat flagged last_row is counted,
// then the row channel stalls while the front end queues one job per ordered pair
// (a, b) of the first column_count columns, a outer and b inner, and clears the
// counts after the last job. The back end works one pair at a time, its pace set
// by the shift-add multiplier for the correlation terms, the 31-step divider for
// the squared correlation and the 16-step square root; the odds, reciprocal and
// mean dividers run alongside. A finished result sits in an output register, so
// the next pair proceeds while it waits. Division by zero and constant columns
// raise the undefined flags instead. The user must write configuration only while
// the block is idle; the block itself does not enforce this.

module pairwise_binary_association_top
	import pba_pkg::*;
	#(
		parameter int MAX_COLUMNS = 8,
		parameter int COUNT_BITS  = 16
	) (
		input  logic             clk,
		input  logic             arst_n,
		pba_row_if.sink          row,
		pba_res_if.source        res,
		input  logic             cfg_we,
		input  cfg_reg_t         cfg_index,
		input  logic [CFG_W-1:0] cfg_wdata
	);

	localparam int AW = $clog2(MAX_COLUMNS);
	localparam int JW = 2*AW + 4*COUNT_BITS + 1;

	// configuration registers
	logic [CCNT_W-1:0]  column_count_q;
	logic [SCALE_W-1:0] error_scale_q;

	// pair job queue
	logic          fj_valid, fj_ready, bj_valid, bj_ready;
	logic [JW-1:0] fj_data, bj_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= COLUMN_COUNT_RST;
			error_scale_q  <= ERROR_SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COLUMN_COUNT: column_count_q <= CCNT_W'(cfg_wdata);
				CFG_ERROR_SCALE:  error_scale_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// counting and pair sequencing
	pba_front #(.M(MAX_COLUMNS), .C(COUNT_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .row(row), .column_count(column_count_q),
		.job_valid(fj_valid), .job_ready(fj_ready), .job_data(fj_data)
	);

	// decouples sequencing from the arithmetic
	pba_fifo #(.W(JW)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(fj_valid), .in_ready(fj_ready), .in_data(fj_data),
		.out_valid(bj_valid), .out_ready(bj_ready), .out_data(bj_data)
	);

	// per-pair statistics
	pba_back #(.M(MAX_COLUMNS), .C(COUNT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(bj_valid), .job_ready(bj_ready),
		.job_data(bj_data), .error_scale(error_scale_q), .res(res)
	);

`ifndef SYNTHESIS
	// the row that closes a matrix stalls the row channel while pairs are queued
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		row.valid && row.ready && row.last_row |=> !row.ready)
		else $error("row channel open right after last row");

	// the final pair of a run is the last diagonal pair
	a_last_diag: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.last_pair |-> res.col_a == res.col_b)
		else $error("last pair is off the diagonal");

	// a diagonal pair always has an empty off-diagonal cell
	a_diag_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.col_a == res.col_b |-> res.ratio_undefined && res.sum_undefined)
		else $error("diagonal pair with defined odds ratio");

	// a non-constant column correlates perfectly with itself
	a_diag_corr: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.col_a == res.col_b && !res.corr_undefined
		|-> res.correlation == 16'sh7FFF)
		else $error("diagonal correlation not saturated at one");
`endif

endmodule

[tb/tb_pairwise_binary_association_top.sv]
// self-checking testbench for pairwise_binary_association_top: row beats in, pair results out
// depends on pba_pkg, pba_if and the rtl of the block; carries its own pair statistics predictor
`timescale 1ns / 1ps

module tb_pairwise_binary_association_top;
	import pba_pkg::*;

	localparam int  NCOLS        = 8;
	localparam int  CNT_MAX      = 65535;
	localparam int  SETTLE_CYC   = 300;       // > one result of back-end work
	localparam int  LIMIT_CYC    = 1500000;
	localparam bit [31:0] SAT32  = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		JOB_ROW,
		JOB_CFG,
		JOB_HOLD
	} job_kind_t;

	typedef struct {
		job_kind_t        kind;
		logic [ROW_W-1:0] bits;
		logic             last;
		logic             no_gap;
		cfg_reg_t         idx;
		logic [CFG_W-1:0] data;
	} job_t;

	typedef struct packed {
		logic [COL_W-1:0]        col_a;
		logic [COL_W-1:0]        col_b;
		logic [Q32_W-1:0]        odds_ratio;
		logic [Q32_W-1:0]        recip_sum;
		logic signed [Q16_W-1:0] correlation;
		logic [Q16_W-1:0]        mean_a;
		logic                    ratio_undefined;
		logic                    sum_undefined;
		logic                    corr_undefined;
		logic                    last_pair;
	} pair_stats_t;

	logic clk;
	logic arst_n;
	logic             cfg_we;
	cfg_reg_t         cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	pba_row_if row_ch ();
	pba_res_if res_ch ();

	pairwise_binary_association_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.row       (row_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// predictor state: own copy of counts and registers
	logic [3:0]  pred_cols;
	logic [7:0]  pred_scale;
	longint unsigned pred_rows;
	longint unsigned pred_ones [NCOLS];
	longint unsigned pred_both [NCOLS][NCOLS];

	job_t        stim_q [$];
	pair_stats_t pair_results_q [$];

	int  mismatches;
	int  row_jobs;
	longint unsigned cycles;

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// floor(|phi| * 32768) by exact integer search, sign applied after
	function automatic logic [15:0] phi_q15(longint unsigned n, longint unsigned na,
		longint unsigned nb, longint unsigned n11);
		bit [127:0] c1, c2, mag, rhs, prod, lhs;
		longint unsigned lo, hi, mid;
		bit neg;
		c1 = n * n11;
		c2 = na * nb;
		neg = c1 < c2;
		mag = neg ? c2 - c1 : c1 - c2;
		rhs = (mag * mag) << 30;
		prod = 128'(na) * 128'(n - na) * 128'(nb) * 128'(n - nb);
		lo = 0;
		hi = 32768;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			lhs = 128'(mid * mid) * prod;
			if (lhs <= rhs) lo = mid;
			else hi = mid - 1;
		end
		if (!neg) return (lo > 32767) ? 16'd32767 : 16'(lo);
		return 16'((65536 - lo) & 16'hFFFF);
	endfunction

	// count one row, and on the last row queue every pair result, then clear
	function automatic void count_row(logic [ROW_W-1:0] bits, logic last);
		int unsigned cols;
		longint unsigned n, na, nb, n11, n10, n01, n00, den, q, s;
		pair_stats_t st;
		bit zc, cc;
		if (pred_rows < CNT_MAX) begin
			pred_rows++;
			for (int a = 0; a < NCOLS; a++) begin
				if (bits[a]) begin
					pred_ones[a]++;
					for (int b = 0; b < NCOLS; b++)
						if (bits[b]) pred_both[a][b]++;
				end
			end
		end
		if (!last) return;
		cols = (pred_cols == 0) ? 1 : (pred_cols > NCOLS) ? NCOLS : pred_cols;
		for (int a = 0; a < cols; a++) begin
			for (int b = 0; b < cols; b++) begin
				n = pred_rows;
				na = pred_ones[a];
				nb = pred_ones[b];
				n11 = pred_both[a][b];
				n10 = na - n11;
				n01 = nb - n11;
				n00 = n - na - nb + n11;
				den = n10 * n01;
				zc = (n11 == 0) || (n10 == 0) || (n01 == 0) || (n00 == 0);
				cc = (na == 0) || (na == n) || (nb == 0) || (nb == n);
				st.col_a = COL_W'(a);
				st.col_b = COL_W'(b);
				if (den == 0) st.odds_ratio = SAT32;
				else begin
					q = ((n11 * n00) << 16) / den;
					st.odds_ratio = (q > SAT32) ? SAT32 : q[31:0];
				end
				if (zc) st.recip_sum = SAT32;
				else begin
					s = (65536 / n11 + 65536 / n00 + 65536 / n10 + 65536 / n01) * pred_scale;
					st.recip_sum = (s > SAT32) ? SAT32 : s[31:0];
				end
				st.correlation = cc ? 16'sd0 : phi_q15(n, na, nb, n11);
				if (n == 0) st.mean_a = '0;
				else begin
					q = (na << 16) / n;
					st.mean_a = (q > 65535) ? 16'hFFFF : q[15:0];
				end
				st.ratio_undefined = (den == 0);
				st.sum_undefined = zc;
				st.corr_undefined = cc;
				st.last_pair = (a == cols - 1) && (b == cols - 1);
				pair_results_q.push_back(st);
			end
		end
		pred_rows = 0;
		foreach (pred_ones[i]) pred_ones[i] = 0;
		foreach (pred_both[i, j]) pred_both[i][j] = 0;
	endfunction

	function automatic void add_row(logic [ROW_W-1:0] bits, logic last, logic no_gap = 0);
		job_t j;
		j.kind = JOB_ROW;
		j.bits = bits;
		j.last = last;
		j.no_gap = no_gap;
		j.idx = CFG_COLUMN_COUNT;
		j.data = '0;
		stim_q.push_back(j);
		row_jobs++;
	endfunction

	function automatic void add_cfg(cfg_reg_t idx, logic [CFG_W-1:0] data);
		job_t j;
		j.kind = JOB_CFG;
		j.bits = '0;
		j.last = 0;
		j.no_gap = 0;
		j.idx = idx;
		j.data = data;
		stim_q.push_back(j);
	endfunction

	function automatic void add_hold();
		job_t j;
		j.kind = JOB_HOLD;
		j.bits = '0;
		j.last = 0;
		j.no_gap = 0;
		j.idx = CFG_COLUMN_COUNT;
		j.data = '0;
		stim_q.push_back(j);
	endfunction

	// row driver: also handles register writes once the block has drained
	int send_gap;
	int settle;
	int calm_left;
	always @(posedge clk or negedge arst_n) begin
		job_t j;
		bit busy;
		if (!arst_n) begin
			row_ch.valid <= 1'b0;
			row_ch.row_bits <= '0;
			row_ch.last_row <= 1'b0;
			cfg_we <= 1'b0;
			cfg_index <= CFG_COLUMN_COUNT;
			cfg_wdata <= '0;
			send_gap = 0;
			settle = 0;
			calm_left = 0;
		end else begin
			busy = row_ch.valid && !row_ch.ready;
			// accepted beat goes into the predictor
			if (row_ch.valid && row_ch.ready)
				count_row(row_ch.row_bits, row_ch.last_row);
			cfg_we <= 1'b0;
			if (!busy) begin
				if (send_gap > 0) begin
					send_gap--;
					row_ch.valid <= 1'b0;
				end else if (stim_q.size() != 0 && stim_q[0].kind != JOB_ROW) begin
					// wait for the block to drain, then let it settle
					row_ch.valid <= 1'b0;
					if (pair_results_q.size() != 0) settle = 0;
					else settle++;
					j = stim_q[0];
					if (j.kind == JOB_HOLD && pair_results_q.size() == 0) begin
						void'(stim_q.pop_front());
						settle = 0;
					end else if (j.kind == JOB_CFG && settle >= SETTLE_CYC) begin
						cfg_we <= 1'b1;
						cfg_index <= j.idx;
						cfg_wdata <= j.data;
						if (j.idx == CFG_COLUMN_COUNT) pred_cols = j.data[3:0];
						else pred_scale = j.data;
						void'(stim_q.pop_front());
						settle = SETTLE_CYC;    // back-to-back writes need no further wait
					end
				end else if (stim_q.size() != 0) begin
					j = stim_q.pop_front();
					row_ch.valid <= 1'b1;
					row_ch.row_bits <= j.bits;
					row_ch.last_row <= j.last;
					settle = 0;
					// stretches with no idling alternate with gappy ones
					if (calm_left > 0) calm_left--;
					else if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(5, 30);
					send_gap = (j.no_gap || calm_left > 0) ? 0 : pick_gap();
				end else begin
					row_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		pair_stats_t got, want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got.col_a = res_ch.col_a;
				got.col_b = res_ch.col_b;
				got.odds_ratio = res_ch.odds_ratio;
				got.recip_sum = res_ch.recip_sum;
				got.correlation = res_ch.correlation;
				got.mean_a = res_ch.mean_a;
				got.ratio_undefined = res_ch.ratio_undefined;
				got.sum_undefined = res_ch.sum_undefined;
				got.corr_undefined = res_ch.corr_undefined;
				got.last_pair = res_ch.last_pair;
				if (pair_results_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result beat: %p", got);
				end else begin
					want = pair_results_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("pair mismatch\n  expected %p\n  actual   %p", want, got);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				stall_left = pick_gap();
				res_ch.ready <= (stall_left == 0) || ($urandom_range(0, 1) == 1);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYC) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int nrows;
		arst_n = 1'b0;
		row_ch.valid = 1'b0;
		row_ch.row_bits = '0;
		row_ch.last_row = 1'b0;
		res_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_COLUMN_COUNT;
		cfg_wdata = '0;
		mismatches = 0;
		row_jobs = 0;
		cycles = 0;
		pred_cols = COLUMN_COUNT_RST;
		pred_scale = ERROR_SCALE_RST;
		pred_rows = 0;
		foreach (pred_ones[i]) pred_ones[i] = 0;
		foreach (pred_both[i, j]) pred_both[i][j] = 0;

		// directed: reset settings, field extremes, diagonal pairs, zero cells
		add_row(8'h00, 0);
		add_row(8'hFF, 0);
		add_row(8'hAA, 0);
		add_row(8'h55, 0);
		add_row(8'h0F, 0);
		add_row(8'h01, 0);
		add_row(8'h80, 1);
		// single all-zero row: constant columns everywhere
		add_row(8'h00, 1);
		// column count zero acts as one, zero scale
		add_cfg(CFG_COLUMN_COUNT, 8'd0);
		add_cfg(CFG_ERROR_SCALE, 8'd0);
		add_row(8'h01, 0);
		add_row(8'h00, 0);
		add_row(8'h03, 0);
		add_row(8'h02, 1);
		// count above max acts as max, largest scale
		add_cfg(CFG_COLUMN_COUNT, 8'd15);
		add_cfg(CFG_ERROR_SCALE, 8'd255);
		add_row(8'h3C, 0);
		add_row(8'hC3, 0);
		add_row(8'h96, 0);
		add_row(8'h69, 0);
		add_row(8'hF0, 1);
		// anti-correlated pair gives phi of -1
		add_cfg(CFG_COLUMN_COUNT, 8'd2);
		add_row(8'h01, 0);
		add_row(8'h02, 1);
		add_cfg(CFG_COLUMN_COUNT, 8'd1);
		add_row(8'h01, 1);

		// random matrices under random settings
		while (row_jobs < 165) begin
			add_cfg(CFG_COLUMN_COUNT, 8'($urandom_range(0, 15)));
			add_cfg(CFG_ERROR_SCALE, 8'($urandom_range(0, 255)));
			nrows = $urandom_range(1, 16);
			for (int i = 0; i < nrows; i++)
				add_row(8'($urandom_range(0, 255)), i == nrows - 1);
			// a stray row leaks into the next matrix now and then
			if ($urandom_range(0, 3) == 0) add_row(8'($urandom_range(0, 255)), 0);
			if ($urandom_range(0, 2) == 0) add_hold();
		end
		add_cfg(CFG_COLUMN_COUNT, 8'd8);
		add_cfg(CFG_ERROR_SCALE, 8'd1);
		add_row(8'hFF, 0);
		add_row(8'h00, 1);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the driver to empty the queue and all results to arrive
		wait (stim_q.size() == 0 && !row_ch.valid && pair_results_q.size() == 0);
		repeat (SETTLE_CYC) @(posedge clk);
		if (mismatches == 0 && pair_results_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[pairwise_binary_association_top.f]
rtl/core/pba_pkg.sv
rtl/core/pba_if.sv
rtl/core/pba_front.sv
rtl/core/pba_fifo.sv
rtl/core/pba_div.sv
rtl/core/pba_back.sv
rtl/core/pairwise_binary_association_top.sv
tb/tb_pairwise_binary_association_top.sv
